FILE: rtl/core/command_line_token_lexer_macros.svh
// Assertion helpers for the command line lexer.
`ifndef COMMAND_LINE_TOKEN_LEXER_MACROS_SVH
`define COMMAND_LINE_TOKEN_LEXER_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define CLT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication checked outside reset.
`define CLT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/core/clt_pkg.sv
package clt_pkg;

  // record kinds
  localparam logic [1:0] RK_CHAR      = 2'd0;
  localparam logic [1:0] RK_TOKEN_END = 2'd1;
  localparam logic [1:0] RK_ERROR     = 2'd2;
  localparam logic [1:0] RK_LINE_DONE = 2'd3;

  // token kinds
  localparam logic [1:0] TK_IDENT  = 2'd0;
  localparam logic [1:0] TK_FLAG   = 2'd1;
  localparam logic [1:0] TK_STRING = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_UNKNOWN_CHAR = 3'd1;
  localparam logic [2:0] ERR_MANY_DASHES  = 3'd2;
  localparam logic [2:0] ERR_DASHES_ONLY  = 3'd3;
  localparam logic [2:0] ERR_UNTERMINATED = 3'd4;
  localparam logic [2:0] ERR_EMPTY_STRING = 3'd5;

  // special bytes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  localparam int unsigned MaxRecs = 3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  tok;
    logic [7:0]  ch;
    logic [11:0] col;
    logic [2:0]  err;
  } rec_t;

endpackage

FILE: rtl/core/command_line_token_lexer.sv
// Command line lexer: one byte per word in, up to three records per byte out.
// Records are registered in the result buffer, then moved one per unstalled cycle to the output register.
// Throughput: 1 byte per cycle while each byte yields at most one record and the output
// is not stalled; a byte yielding more holds the input until its last record is handed on.
// Reset: asynchronous, active low; lexer idle at column 0, max_dashes = 2,
// result buffer and output register empty.
module command_line_token_lexer import clt_pkg::*; #(
  parameter int unsigned LINE_MAX = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: max_dashes
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,
  // byte channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  input  logic        end_of_line_i,
  // record channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  record_kind_o,
  output logic [1:0]  token_kind_o,
  output logic [7:0]  out_char_o,
  output logic [11:0] column_o,
  output logic [2:0]  error_code_o,
  output logic        last_of_run_o
);

  localparam int unsigned CW = $clog2(LINE_MAX);

  // lexer modes
  localparam logic [2:0] M_IDLE     = 3'd0;
  localparam logic [2:0] M_IDENT    = 3'd1;
  localparam logic [2:0] M_DASHES   = 3'd2;
  localparam logic [2:0] M_FLAGBODY = 3'd3;
  localparam logic [2:0] M_STRING   = 3'd4;
  localparam logic [2:0] M_ERROR    = 3'd5;

  function automatic logic is_alnum(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic rec_t mk_rec(input logic [1:0] kind, input logic [1:0] tok,
                                  input logic [7:0] ch, input logic [11:0] col,
                                  input logic [2:0] err);
    rec_t r;
    r.kind = kind;
    r.tok  = tok;
    r.ch   = ch;
    r.col  = col;
    r.err  = err;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Lexer state
  // ---------------------------------------------------------------------------
  logic [2:0]    max_dashes_q;
  logic [2:0]    mode_q, mode_d;
  logic [2:0]    dash_q, dash_d;
  logic [CW-1:0] col_q, col_d;      // column of the next byte, saturated
  logic [CW-1:0] start_q, start_d;  // token start column
  logic          text_q, text_d;    // string holds a non-space byte

  logic          in_acc;

  // column as seen at the 12-bit record field
  logic [CW-1:0]    nxt;
  logic [CW+11:0]   col_x, nxt_x, start_x;
  logic [11:0]      col12, nxt12, start12;

  assign nxt     = (col_q == CW'(LINE_MAX - 1)) ? col_q : col_q + CW'(1);
  assign col_x   = {12'b0, col_q};
  assign nxt_x   = {12'b0, nxt};
  assign start_x = {12'b0, start_q};
  assign col12   = col_x[11:0];
  assign nxt12   = nxt_x[11:0];
  assign start12 = start_x[11:0];

  // ---------------------------------------------------------------------------
  // Single-pass step: records for this byte and the next state
  // ---------------------------------------------------------------------------
  rec_t       recs [MaxRecs];
  logic [1:0] n_rec;

  always_comb begin
    logic        from_idle;
    logic        do_dash;
    logic [3:0]  dash_cnt;
    logic [11:0] dash_col;
    logic [1:0]  cur_tok;

    mode_d  = mode_q;
    dash_d  = dash_q;
    col_d   = col_q;
    start_d = start_q;
    text_d  = text_q;
    n_rec   = 2'd0;
    for (int i = 0; i < MaxRecs; i++) begin
      recs[i] = '0;
    end
    from_idle = 1'b0;
    do_dash   = 1'b0;
    cur_tok   = (mode_q == M_IDENT) ? TK_IDENT : TK_FLAG;
    // a dash straight from idle counts as the first one, errors at its own column
    dash_cnt  = (mode_q == M_DASHES) ? {1'b0, dash_q} + 4'd1 : 4'd1;
    dash_col  = (mode_q == M_DASHES) ? start12 : col12;

    case (mode_q)
      M_IDLE: begin
        from_idle = 1'b1;
      end
      M_IDENT, M_FLAGBODY: begin
        if (is_alnum(ch_i)) begin
          recs[n_rec] = mk_rec(RK_CHAR, cur_tok, ch_i, 12'd0, ERR_NONE);
          n_rec = n_rec + 2'd1;
        end else begin
          // token ended by this byte; the byte is then lexed as from idle
          recs[n_rec] = mk_rec(RK_TOKEN_END, cur_tok, 8'd0, col12, ERR_NONE);
          n_rec = n_rec + 2'd1;
          mode_d = M_IDLE;
          from_idle = 1'b1;
        end
      end
      M_DASHES: begin
        if (ch_i == CH_DASH) begin
          do_dash = 1'b1;
        end else if (is_alnum(ch_i)) begin
          mode_d = M_FLAGBODY;
          recs[n_rec] = mk_rec(RK_CHAR, TK_FLAG, ch_i, 12'd0, ERR_NONE);
          n_rec = n_rec + 2'd1;
        end else begin
          recs[n_rec] = mk_rec(RK_ERROR, TK_FLAG, 8'd0, start12, ERR_DASHES_ONLY);
          n_rec = n_rec + 2'd1;
          mode_d = M_ERROR;
        end
      end
      M_STRING: begin
        if (ch_i == CH_QUOTE) begin
          if (text_q) begin
            recs[n_rec] = mk_rec(RK_TOKEN_END, TK_STRING, 8'd0, nxt12, ERR_NONE);
            n_rec = n_rec + 2'd1;
            mode_d = M_IDLE;
          end else begin
            recs[n_rec] = mk_rec(RK_ERROR, TK_STRING, 8'd0, start12, ERR_EMPTY_STRING);
            n_rec = n_rec + 2'd1;
            mode_d = M_ERROR;
          end
        end else begin
          if (ch_i != CH_SPACE) begin
            text_d = 1'b1;
          end
          recs[n_rec] = mk_rec(RK_CHAR, TK_STRING, ch_i, 12'd0, ERR_NONE);
          n_rec = n_rec + 2'd1;
        end
      end
      default: begin
        mode_d = M_ERROR;
      end
    endcase

    if (from_idle) begin
      if (ch_i == CH_SPACE) begin
        // separator, nothing to do
      end else if (is_alnum(ch_i)) begin
        start_d = col_q;
        mode_d  = M_IDENT;
        recs[n_rec] = mk_rec(RK_CHAR, TK_IDENT, ch_i, 12'd0, ERR_NONE);
        n_rec = n_rec + 2'd1;
      end else if (ch_i == CH_DASH) begin
        start_d = col_q;
        do_dash = 1'b1;
      end else if (ch_i == CH_QUOTE) begin
        start_d = nxt;
        text_d  = 1'b0;
        mode_d  = M_STRING;
      end else begin
        recs[n_rec] = mk_rec(RK_ERROR, TK_IDENT, 8'd0, col12, ERR_UNKNOWN_CHAR);
        n_rec = n_rec + 2'd1;
        mode_d = M_ERROR;
      end
    end

    if (do_dash) begin
      if (dash_cnt > {1'b0, max_dashes_q}) begin
        recs[n_rec] = mk_rec(RK_ERROR, TK_FLAG, 8'd0, dash_col, ERR_MANY_DASHES);
        n_rec = n_rec + 2'd1;
        mode_d = M_ERROR;
      end else if (end_of_line_i) begin
        // flag still dashes only at line end
        recs[n_rec] = mk_rec(RK_ERROR, TK_FLAG, 8'd0, dash_col, ERR_DASHES_ONLY);
        n_rec = n_rec + 2'd1;
        mode_d = M_ERROR;
      end else begin
        dash_d = dash_cnt[2:0];
        mode_d = M_DASHES;
        recs[n_rec] = mk_rec(RK_CHAR, TK_FLAG, CH_DASH, 12'd0, ERR_NONE);
        n_rec = n_rec + 2'd1;
      end
    end

    if (end_of_line_i) begin
      if (mode_d == M_IDENT) begin
        recs[n_rec] = mk_rec(RK_TOKEN_END, TK_IDENT, 8'd0, nxt12, ERR_NONE);
        n_rec = n_rec + 2'd1;
      end else if (mode_d == M_FLAGBODY) begin
        recs[n_rec] = mk_rec(RK_TOKEN_END, TK_FLAG, 8'd0, nxt12, ERR_NONE);
        n_rec = n_rec + 2'd1;
      end else if (mode_d == M_DASHES) begin
        recs[n_rec] = mk_rec(RK_ERROR, TK_FLAG, 8'd0, start12, ERR_DASHES_ONLY);
        n_rec = n_rec + 2'd1;
      end else if (mode_d == M_STRING) begin
        recs[n_rec] = mk_rec(RK_ERROR, TK_STRING, 8'd0, start12, ERR_UNTERMINATED);
        n_rec = n_rec + 2'd1;
      end
      recs[n_rec] = mk_rec(RK_LINE_DONE, TK_IDENT, 8'd0, nxt12, ERR_NONE);
      n_rec = n_rec + 2'd1;
      mode_d  = M_IDLE;
      dash_d  = 3'd0;
      col_d   = '0;
      start_d = '0;
      text_d  = 1'b0;
    end else begin
      col_d = nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dashes_q <= 3'd2;
      mode_q       <= M_IDLE;
      dash_q       <= 3'd0;
      col_q        <= '0;
      start_q      <= '0;
      text_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_dashes_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        mode_q  <= mode_d;
        dash_q  <= dash_d;
        col_q   <= col_d;
        start_q <= start_d;
        text_q  <= text_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result buffer: the records of one byte, drained one per cycle into the
  // output register while the output is not stalled. A new byte is taken once the buffer hands over its last.
  // ---------------------------------------------------------------------------
  rec_t       buf_q [MaxRecs];
  logic [1:0] buf_cnt_q;
  logic [1:0] buf_idx_q;
  logic       buf_busy;
  logic       buf_last;
  logic       out_load;

  rec_t       out_rec_q;
  logic       out_valid_q;
  logic       out_last_q;

  assign buf_busy   = (buf_idx_q != buf_cnt_q);
  assign buf_last   = (buf_idx_q + 2'd1 == buf_cnt_q);
  assign out_load   = buf_busy && (!out_valid_q || !out_stall_i);
  assign in_stall_o = buf_busy && !(out_load && buf_last);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_cnt_q <= 2'd0;
      buf_idx_q <= 2'd0;
    end else if (in_acc) begin
      buf_cnt_q <= n_rec;
      buf_idx_q <= 2'd0;
    end else if (out_load) begin
      buf_idx_q <= buf_idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      buf_q <= recs;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_rec_q  <= buf_q[buf_idx_q];
      out_last_q <= buf_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign record_kind_o = out_rec_q.kind;
  assign token_kind_o  = out_rec_q.tok;
  assign out_char_o    = out_rec_q.ch;
  assign column_o      = out_rec_q.col;
  assign error_code_o  = out_rec_q.err;
  assign last_of_run_o = out_last_q;

endmodule

FILE: rtl/core/clt_checker.sv
`include "command_line_token_lexer_macros.svh"

module clt_checker import clt_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  ch_i,
  input logic        end_of_line_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  record_kind_o,
  input logic [1:0]  token_kind_o,
  input logic [7:0]  out_char_o,
  input logic [11:0] column_o,
  input logic [2:0]  error_code_o,
  input logic        last_of_run_o
);

  // stalled byte holds
  `CLT_ASSERT(a_in_hold, clk_i, rst_ni,
    (in_valid_i && in_stall_o) |=> (in_valid_i && $stable(ch_i) && $stable(end_of_line_i)),
    "stalled byte changed")

  // stalled word holds
  `CLT_ASSERT(a_out_hold, clk_i, rst_ni,
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(record_kind_o)
      && $stable(token_kind_o) && $stable(column_o) && $stable(out_char_o)
      && $stable(error_code_o) && $stable(last_of_run_o)),
    "stalled record changed")

  // records of one byte follow without a gap
  `CLT_ASSERT(a_run_cont, clk_i, rst_ni,
    (out_valid_o && !out_stall_i && !last_of_run_o) |=> out_valid_o,
    "gap inside a record run")

  // line finished always closes its run
  `CLT_ASSERT_IMP(a_line_last, clk_i, rst_ni,
    out_valid_o && record_kind_o == RK_LINE_DONE, last_of_run_o,
    "line finished not last")

  // non-error records carry no error code, and only character records among them a byte
  `CLT_ASSERT_IMP(a_fields, clk_i, rst_ni,
    out_valid_o && record_kind_o != RK_ERROR,
    error_code_o == ERR_NONE && (record_kind_o == RK_CHAR || out_char_o == 8'd0),
    "stray field in record")

endmodule

bind command_line_token_lexer clt_checker u_clt_checker (.*);

FILE: tb/sv/tb_top.sv
module tb_top;
  import clt_pkg::*;

  localparam int LineMax    = 4096;
  localparam int QuietLimit = 1000;  // cycles with no word moving on either side

  // Lexer modes of the predictor
  typedef enum logic [2:0] {
    LX_IDLE, LX_IDENT, LX_DASHES, LX_FLAG, LX_STRING, LX_HALTED
  } lex_mode_e;

  // One byte of a command line as the sender holds it
  typedef struct packed {
    logic [7:0] ch;
    logic       eol;
  } line_byte_t;

  // One output record, with its end-of-run marker
  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  tok;
    logic [7:0]  ch;
    logic [11:0] col;
    logic [2:0]  err;
    logic        last;
  } lex_rec_t;

  // DUT ports; every input starts at a known value
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [2:0]  cfg_wdata_i   = '0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [7:0]  ch_i          = '0;
  logic        end_of_line_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [1:0]  record_kind_o;
  logic [1:0]  token_kind_o;
  logic [7:0]  out_char_o;
  logic [11:0] column_o;
  logic [2:0]  error_code_o;
  logic        last_of_run_o;

  // Stimulus and expected records
  line_byte_t pending_bytes[$];
  lex_rec_t   expected_recs[$];
  lex_rec_t   step_recs[$];

  // Predictor state and its copy of max_dashes
  lex_mode_e  lx_mode       = LX_IDLE;
  int         lx_dashes     = 0;
  int         lx_col        = 0;
  int         lx_tok_start  = 0;
  bit         lx_str_text   = 1'b0;
  int         lx_dash_limit = 2;

  // Handshake bookkeeping between posedge monitor and negedge drivers
  bit byte_took  = 1'b0;
  bit rec_took   = 1'b0;
  int gap_left   = 0;
  int stall_left = 0;
  bit src_lazy   = 1'b1;
  bit sink_lazy  = 1'b1;
  int mismatches = 0;
  int quiet_cycles = 0;

  command_line_token_lexer #(
    .LINE_MAX(LineMax)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .ch_i          (ch_i),
    .end_of_line_i (end_of_line_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .record_kind_o (record_kind_o),
    .token_kind_o  (token_kind_o),
    .out_char_o    (out_char_o),
    .column_o      (column_o),
    .error_code_o  (error_code_o),
    .last_of_run_o (last_of_run_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor: mirrors the lexer one byte at a time
  // ---------------------------------------------------------------------------

  function automatic bit is_alnum(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  // columns stick at the last one a line can hold
  function automatic int sat_col(int c);
    return (c > LineMax - 1) ? LineMax - 1 : c;
  endfunction

  // at most three records per byte; anything beyond is dropped
  task automatic put_rec(logic [1:0] kind, logic [1:0] tok, logic [7:0] c, int col,
                         logic [2:0] err);
    lex_rec_t r;
    r.kind = kind;
    r.tok  = tok;
    r.ch   = c;
    r.col  = col[11:0];
    r.err  = err;
    r.last = 1'b0;
    if (step_recs.size() < MaxRecs) step_recs.push_back(r);
  endtask

  // first error of a line: report it, then ignore bytes until line end
  task automatic halt_line(logic [1:0] tok, int col, logic [2:0] err);
    put_rec(RK_ERROR, tok, 8'h00, col, err);
    lx_mode = LX_HALTED;
  endtask

  task automatic take_dash(bit first, bit eol);
    int cnt;
    cnt = first ? 1 : lx_dashes + 1;
    if (cnt > lx_dash_limit) begin
      halt_line(TK_FLAG, lx_tok_start, ERR_MANY_DASHES);
    end else if (eol) begin
      // a flag still made only of dashes at line end
      halt_line(TK_FLAG, lx_tok_start, ERR_DASHES_ONLY);
    end else begin
      lx_dashes = cnt;
      lx_mode   = LX_DASHES;
      put_rec(RK_CHAR, TK_FLAG, CH_DASH, 0, ERR_NONE);
    end
  endtask

  task automatic start_token(logic [7:0] c, int col, bit eol);
    if (c == CH_SPACE) begin
      // separator, nothing to report
    end else if (is_alnum(c)) begin
      lx_tok_start = col;
      lx_mode      = LX_IDENT;
      put_rec(RK_CHAR, TK_IDENT, c, 0, ERR_NONE);
    end else if (c == CH_DASH) begin
      lx_tok_start = col;
      take_dash(1'b1, eol);
    end else if (c == CH_QUOTE) begin
      // string errors point just past the opening quote
      lx_tok_start = sat_col(col + 1);
      lx_str_text  = 1'b0;
      lx_mode      = LX_STRING;
    end else begin
      halt_line(TK_IDENT, col, ERR_UNKNOWN_CHAR);
    end
  endtask

  // Works out the records of one accepted byte and queues them
  task automatic lex_predict(logic [7:0] c, bit eol);
    int col;
    int nxt;
    logic [1:0] open_tok;
    col = sat_col(lx_col);
    nxt = sat_col(col + 1);
    step_recs.delete();

    case (lx_mode)
      LX_IDLE: start_token(c, col, eol);
      LX_IDENT, LX_FLAG: begin
        open_tok = (lx_mode == LX_IDENT) ? TK_IDENT : TK_FLAG;
        if (is_alnum(c)) begin
          put_rec(RK_CHAR, open_tok, c, 0, ERR_NONE);
        end else begin
          // token ends here, then the byte is taken as if idle
          put_rec(RK_TOKEN_END, open_tok, 8'h00, col, ERR_NONE);
          lx_mode = LX_IDLE;
          start_token(c, col, eol);
        end
      end
      LX_DASHES: begin
        if (c == CH_DASH) begin
          take_dash(1'b0, eol);
        end else if (is_alnum(c)) begin
          lx_mode = LX_FLAG;
          put_rec(RK_CHAR, TK_FLAG, c, 0, ERR_NONE);
        end else begin
          halt_line(TK_FLAG, lx_tok_start, ERR_DASHES_ONLY);
        end
      end
      LX_STRING: begin
        if (c == CH_QUOTE) begin
          if (lx_str_text) begin
            put_rec(RK_TOKEN_END, TK_STRING, 8'h00, nxt, ERR_NONE);
            lx_mode = LX_IDLE;
          end else begin
            halt_line(TK_STRING, lx_tok_start, ERR_EMPTY_STRING);
          end
        end else begin
          if (c != CH_SPACE) lx_str_text = 1'b1;
          put_rec(RK_CHAR, TK_STRING, c, 0, ERR_NONE);
        end
      end
      default: lx_mode = LX_HALTED;
    endcase

    if (eol) begin
      // close whatever is open, then report the line as finished
      if (lx_mode == LX_IDENT || lx_mode == LX_FLAG) begin
        put_rec(RK_TOKEN_END, (lx_mode == LX_IDENT) ? TK_IDENT : TK_FLAG, 8'h00, nxt,
                ERR_NONE);
      end else if (lx_mode == LX_DASHES) begin
        halt_line(TK_FLAG, lx_tok_start, ERR_DASHES_ONLY);
      end else if (lx_mode == LX_STRING) begin
        halt_line(TK_STRING, lx_tok_start, ERR_UNTERMINATED);
      end
      put_rec(RK_LINE_DONE, TK_IDENT, 8'h00, nxt, ERR_NONE);
      lx_mode      = LX_IDLE;
      lx_dashes    = 0;
      lx_col       = 0;
      lx_tok_start = 0;
      lx_str_text  = 1'b0;
    end else begin
      lx_col = nxt;
    end

    if (step_recs.size() > 0) step_recs[step_recs.size() - 1].last = 1'b1;
    foreach (step_recs[i]) expected_recs.push_back(step_recs[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: checks records first, then predicts from the byte taken this edge.
  // Doing it in that order keeps the outcome independent of process order.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    lex_rec_t got;
    lex_rec_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        rec_took = 1'b1;
        got.kind = record_kind_o;
        got.tok  = token_kind_o;
        got.ch   = out_char_o;
        got.col  = column_o;
        got.err  = error_code_o;
        got.last = last_of_run_o;
        if (expected_recs.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: record with nothing expected: kind=%0d tok=%0d ch=%02h col=%0d err=%0d last=%0b",
                     $realtime, got.kind, got.tok, got.ch, got.col, got.err, got.last);
          mismatches++;
        end else begin
          want = expected_recs.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display("%0t: record mismatch exp kind=%0d tok=%0d ch=%02h col=%0d err=%0d last=%0b | got kind=%0d tok=%0d ch=%02h col=%0d err=%0d last=%0b",
                       $realtime, want.kind, want.tok, want.ch, want.col, want.err,
                       want.last, got.kind, got.tok, got.ch, got.col, got.err, got.last);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        byte_took = 1'b1;
        lex_predict(ch_i, end_of_line_i);
      end
    end
  end

  // Byte driver: pops the next word after a random gap, holds it while stalled
  always @(negedge clk_i) begin : byte_driver
    line_byte_t nb;
    if (rst_ni) begin
      if (!in_valid_i || byte_took) begin
        byte_took = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          nb = pending_bytes.pop_front();
          ch_i          <= nb.ch;
          end_of_line_i <= nb.eol;
          in_valid_i    <= 1'b1;
          gap_left = src_lazy ? $urandom_range(0, 3) : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Record sink: random stall after each record taken, sometimes while idle too
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rec_took) begin
        rec_took   = 1'b0;
        stall_left = sink_lazy ? $urandom_range(0, 3) : 0;
      end else if (!out_valid_o && stall_left == 0 && sink_lazy && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog on cycles where no word moves at all
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic push_byte(logic [7:0] c, logic eol);
    line_byte_t b;
    b.ch  = c;
    b.eol = eol;
    pending_bytes.push_back(b);
  endtask

  // whole line from text, end-of-line on its last byte
  task automatic push_line(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], i == s.len() - 1);
  endtask

  // sender holds off until every byte is in and every record is out
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_valid_i || expected_recs.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic set_dash_limit(int v);
    wait_drained();
    // spaces make no records but may still be in the pipe
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v[2:0];
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    lx_dash_limit = v;
  endtask

  function automatic logic [7:0] pick_alnum();
    case ($urandom_range(0, 2))
      0:       return 8'("0" + $urandom_range(0, 9));
      1:       return 8'("A" + $urandom_range(0, 25));
      default: return 8'("a" + $urandom_range(0, 25));
    endcase
  endfunction

  // a byte that no token may hold
  function automatic logic [7:0] pick_junk();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (is_alnum(c) || c == CH_SPACE || c == CH_DASH || c == CH_QUOTE)
      c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // Random line of ntok tokens; noisy lines also carry broken pieces.
  // With hold_mid the sender drains the block halfway through the line.
  task automatic gen_line(int ntok, bit noisy, bit hold_mid);
    logic [7:0] txt[$];
    logic [7:0] c;
    int len;
    int kind;
    bit has_text;
    src_lazy  = ($urandom_range(0, 3) != 0);
    sink_lazy = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 3) == 0) txt.push_back(CH_SPACE);
    for (int k = 0; k < ntok; k++) begin
      kind = (noisy && $urandom_range(0, 3) == 0) ? 3 : $urandom_range(0, 2);
      case (kind)
        0: begin  // identifier
          len = $urandom_range(1, 6);
          repeat (len) txt.push_back(pick_alnum());
        end
        1: begin  // flag within the dash limit
          len = $urandom_range(1, lx_dash_limit);
          repeat (len) txt.push_back(CH_DASH);
          len = $urandom_range(1, 4);
          repeat (len) txt.push_back(pick_alnum());
        end
        2: begin  // string with at least one non-space byte, any byte but a quote
          txt.push_back(CH_QUOTE);
          len = $urandom_range(1, 5);
          has_text = 1'b0;
          for (int j = 0; j < len; j++) begin
            case ($urandom_range(0, 3))
              0:       c = CH_SPACE;
              1: begin
                c = 8'($urandom_range(0, 255));
                while (c == CH_QUOTE) c = 8'($urandom_range(0, 255));
              end
              default: c = pick_alnum();
            endcase
            if (j == len - 1 && !has_text && c == CH_SPACE) c = pick_alnum();
            if (c != CH_SPACE) has_text = 1'b1;
            txt.push_back(c);
          end
          txt.push_back(CH_QUOTE);
        end
        default: begin  // broken piece
          case ($urandom_range(0, 4))
            0: txt.push_back(pick_junk());
            1: begin  // one dash too many, or more
              len = $urandom_range(lx_dash_limit + 1, 8);
              repeat (len) txt.push_back(CH_DASH);
              txt.push_back(pick_alnum());
            end
            2: begin  // dashes with no body
              len = $urandom_range(1, lx_dash_limit);
              repeat (len) txt.push_back(CH_DASH);
              txt.push_back(CH_SPACE);
            end
            3: begin  // empty or blank string
              txt.push_back(CH_QUOTE);
              len = $urandom_range(0, 2);
              repeat (len) txt.push_back(CH_SPACE);
              txt.push_back(CH_QUOTE);
            end
            default: begin  // string left open
              txt.push_back(CH_QUOTE);
              txt.push_back(pick_alnum());
            end
          endcase
        end
      endcase
      len = $urandom_range(0, 3);
      if (len > 2) len = 1;
      repeat (len) txt.push_back(CH_SPACE);
    end
    // dash as the very last byte of the line
    if (noisy && $urandom_range(0, 5) == 0) txt.push_back(CH_DASH);
    if (txt.size() == 0) txt.push_back(CH_SPACE);

    foreach (txt[i]) begin
      push_byte(txt[i], i == txt.size() - 1);
      if (hold_mid && i == txt.size() / 2) wait_drained();
    end
  endtask

  initial begin : stimulus
    int dash_settings[6];
    dash_settings = '{1, 7, 3, 5, 4, 6};

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed lines under the reset dash limit of two
    push_line("Az -b \"k\"");   // all three token kinds, string closed at line end
    push_line("x-");            // identifier cut by a dash on the last byte
    push_line("---");           // third dash on the last byte: too many dashes
    push_line("\"\"");          // empty string
    push_line("\"a");           // string left open at line end
    push_line("-!");            // flag made only of dashes
    push_byte(8'hFF, 1'b1);     // unknown bytes at both ends of the range
    push_byte(8'h00, 1'b1);

    // Random lines across dash limits, extremes first
    foreach (dash_settings[p]) begin
      set_dash_limit(dash_settings[p]);
      for (int n = 0; n < 3; n++)
        gen_line($urandom_range(1, 5), $urandom_range(0, 3) != 0, p == 2 && n == 1);
    end

    // A few more random lines under the reset value again
    set_dash_limit(2);
    for (int n = 0; n < 3; n++) gen_line($urandom_range(1, 5), 1'b1, 1'b0);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
